@@ rtl/core/irpd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the infrared pulse-distance transmitter.
// Holds the phase type, status, command and register codes, reset values and bit search result; no dependencies.

package irpd_pkg;

    // Longest code word that a start may ask for, and the width of the code port.
    localparam int MAX_BITS = 32;
    localparam int CODE_W   = 32;
    localparam int LEN_W    = 6;
    localparam int IDX_W    = 5;

    // Transmit phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD_MARK,
        PH_LEAD_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_TRAILER
    } phase_t;

    // Start status reported with each result word.
    localparam logic [1:0] STATUS_NONE   = 2'd0;
    localparam logic [1:0] STATUS_ACCEPT = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    // Command codes.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_CARRIER_HIGH = 3'd0;
    localparam logic [2:0] REG_CARRIER_LOW  = 3'd1;
    localparam logic [2:0] REG_LEAD_MARK    = 3'd2;
    localparam logic [2:0] REG_LEAD_SPACE   = 3'd3;
    localparam logic [2:0] REG_ONE_MARK     = 3'd4;
    localparam logic [2:0] REG_ZERO_MARK    = 3'd5;
    localparam logic [2:0] REG_ONE_SPACE    = 3'd6;
    localparam logic [2:0] REG_ZERO_SPACE   = 3'd7;

    // Register reset values.
    localparam logic [9:0]  RST_CARRIER_HIGH = 10'd13;
    localparam logic [9:0]  RST_CARRIER_LOW  = 10'd13;
    localparam logic [9:0]  RST_LEAD_MARK    = 10'd6;
    localparam logic [15:0] RST_LEAD_SPACE   = 16'd1014;
    localparam logic [9:0]  RST_ONE_MARK     = 10'd6;
    localparam logic [9:0]  RST_ZERO_MARK    = 10'd6;
    localparam logic [15:0] RST_ONE_SPACE    = 16'd546;
    localparam logic [15:0] RST_ZERO_SPACE   = 16'd260;

    // Result of the search for the next bit that takes time.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } bit_hit_t;

endpackage

@@ rtl/core/irpd_bit_search.sv @@
`timescale 1ns / 1ps
// Finds the highest code bit below a limit whose mark or space is not empty.
// Depends on irpd_pkg.

module irpd_bit_search
    import irpd_pkg::*;
(
    input  logic [CODE_W-1:0] word,
    input  logic [LEN_W-1:0]  limit,
    input  logic              skip_one,
    input  logic              skip_zero,
    output bit_hit_t          hit
);

    // Priority search from the low end up, so the highest qualifying bit wins.
    always_comb begin
        hit.found = 1'b0;
        hit.idx   = '0;
        for (int i = 0; i < CODE_W; i++) begin
            if ((LEN_W'(i) < limit) && !(word[i] ? skip_one : skip_zero)) begin
                hit.found = 1'b1;
                hit.idx   = IDX_W'(i);
            end
        end
    end

endmodule

@@ rtl/core/ir_pulse_distance_transmitter.sv @@
`timescale 1ns / 1ps
// Top level of the infrared pulse-distance transmitter.
// Depends on irpd_pkg and irpd_bit_search.

// Each input word is either a one-microsecond tick or a start command, and each
// produces exactly one result word with the output level for that microsecond,
// the busy and done flags and the start status. One input word is taken every
// clock while s_ready is high: the phase and counter update is a single pass of
// compares and a 32-bit priority search for the next bit that takes time, so
// phases of zero length are skipped within the same word. The result sits in
// one output register; s_ready drops only while that register is full and
// m_ready is low, and a result appears in the cycle after its input word is
// taken. Configuration registers are written through cfg_we, cfg_index and
// cfg_data and take effect at once, also while a code is going out.

module ir_pulse_distance_transmitter
    import irpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Input channel.
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [CODE_W-1:0] s_code_bits,
    input  logic [LEN_W-1:0]  s_code_length,
    input  logic              s_trailer_enable,
    // Result channel.
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_ir_level,
    output logic              m_busy_res,
    output logic              m_done_res,
    output logic [1:0]        m_start_status,
    // Configuration write port.
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    // Configuration registers.
    logic [9:0]  carrier_high_reg, carrier_low_reg, lead_mark_reg;
    logic [9:0]  one_mark_reg, zero_mark_reg;
    logic [15:0] lead_space_reg, one_space_reg, zero_space_reg;

    // Transmit state.
    phase_t            phase_reg, phase_next;
    logic              half_reg, half_next;
    logic [15:0]       us_cnt_reg, us_cnt_next;
    logic [9:0]        cyc_cnt_reg, cyc_cnt_next;
    logic [CODE_W-1:0] shift_reg, shift_next;
    logic [LEN_W-1:0]  bits_left_reg, bits_left_next;
    logic              trailer_reg, trailer_next;

    // Result register.
    logic       m_valid_reg, m_valid_next;
    logic       level_reg, busy_reg, done_reg;
    logic [1:0] status_reg;

    logic       take;
    logic       is_start, start_ok;
    logic       res_level, res_busy, res_done;
    logic [1:0] res_status;
    logic       phase_end;

    logic [IDX_W-1:0]  cur_idx;
    logic              cur_bit;
    logic [9:0]        mark_len;
    logic [15:0]       space_len;
    logic [9:0]        high_len, low_len;
    logic [15:0]       us_inc;
    logic [9:0]        cyc_inc;
    logic              skip_one, skip_zero;

    logic [CODE_W-1:0] search_word;
    logic [LEN_W-1:0]  search_limit;
    logic              search_trailer;
    bit_hit_t          hit;
    logic              hit_bit;
    phase_t            enter_phase;
    logic [LEN_W-1:0]  enter_bits;

    assign take     = s_valid && s_ready;
    assign is_start = (s_cmd == CMD_START);
    assign start_ok = (phase_reg == PH_IDLE) && (s_code_length <= LEN_W'(MAX_BITS));

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carrier_high_reg <= RST_CARRIER_HIGH;
            carrier_low_reg  <= RST_CARRIER_LOW;
            lead_mark_reg    <= RST_LEAD_MARK;
            lead_space_reg   <= RST_LEAD_SPACE;
            one_mark_reg     <= RST_ONE_MARK;
            zero_mark_reg    <= RST_ZERO_MARK;
            one_space_reg    <= RST_ONE_SPACE;
            zero_space_reg   <= RST_ZERO_SPACE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CARRIER_HIGH: carrier_high_reg <= cfg_data[9:0];
                REG_CARRIER_LOW:  carrier_low_reg  <= cfg_data[9:0];
                REG_LEAD_MARK:    lead_mark_reg    <= cfg_data[9:0];
                REG_LEAD_SPACE:   lead_space_reg   <= cfg_data;
                REG_ONE_MARK:     one_mark_reg     <= cfg_data[9:0];
                REG_ZERO_MARK:    zero_mark_reg    <= cfg_data[9:0];
                REG_ONE_SPACE:    one_space_reg    <= cfg_data;
                REG_ZERO_SPACE:   zero_space_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Lengths of the current phase; a zero carrier half counts as one microsecond.
    assign cur_idx  = IDX_W'(bits_left_reg - LEN_W'(1));
    assign cur_bit  = shift_reg[cur_idx];
    assign high_len = (carrier_high_reg == '0) ? 10'd1 : carrier_high_reg;
    assign low_len  = (carrier_low_reg == '0) ? 10'd1 : carrier_low_reg;
    assign us_inc   = us_cnt_reg + 16'd1;
    assign cyc_inc  = cyc_cnt_reg + 10'd1;

    always_comb begin
        mark_len  = one_mark_reg;
        space_len = lead_space_reg;
        case (phase_reg)
            PH_LEAD_MARK: mark_len = lead_mark_reg;
            PH_BIT_MARK:  mark_len = cur_bit ? one_mark_reg : zero_mark_reg;
            default:      mark_len = one_mark_reg;
        endcase
        case (phase_reg)
            PH_BIT_SPACE, PH_BIT_MARK: space_len = cur_bit ? one_space_reg : zero_space_reg;
            default:                   space_len = lead_space_reg;
        endcase
    end

    // A bit is skipped outright when both its mark and its space are empty.
    assign skip_one  = (one_mark_reg == '0) && (one_space_reg == '0);
    assign skip_zero = (zero_mark_reg == '0) && (zero_space_reg == '0);

    // Search window: the new code on a start, otherwise the bits still to send.
    always_comb begin
        if (is_start) begin
            search_word    = s_code_bits;
            search_limit   = s_code_length;
            search_trailer = s_trailer_enable;
        end else begin
            search_word    = shift_reg;
            search_trailer = trailer_reg;
            if (phase_reg == PH_LEAD_MARK || phase_reg == PH_LEAD_SPACE) begin
                search_limit = bits_left_reg;
            end else begin
                search_limit = bits_left_reg - LEN_W'(1);
            end
        end
    end

    irpd_bit_search u_bit_search (
        .word      (search_word),
        .limit     (search_limit),
        .skip_one  (skip_one),
        .skip_zero (skip_zero),
        .hit       (hit)
    );

    // Phase reached when moving on to the bits: first non-empty bit, else trailer or idle.
    assign hit_bit = search_word[hit.idx];

    always_comb begin
        if (hit.found) begin
            enter_bits = {1'b0, hit.idx} + LEN_W'(1);
            if ((hit_bit ? one_mark_reg : zero_mark_reg) != '0) begin
                enter_phase = PH_BIT_MARK;
            end else begin
                enter_phase = PH_BIT_SPACE;
            end
        end else begin
            enter_bits = '0;
            if (search_trailer && (one_mark_reg != '0)) begin
                enter_phase = PH_TRAILER;
            end else begin
                enter_phase = PH_IDLE;
            end
        end
    end

    // Next transmit state.
    always_comb begin
        phase_next     = phase_reg;
        half_next      = half_reg;
        us_cnt_next    = us_cnt_reg;
        cyc_cnt_next   = cyc_cnt_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        trailer_next   = trailer_reg;
        phase_end      = 1'b0;
        if (take) begin
            if (is_start) begin
                if (start_ok) begin
                    shift_next     = s_code_bits;
                    trailer_next   = s_trailer_enable;
                    half_next      = 1'b0;
                    us_cnt_next    = '0;
                    cyc_cnt_next   = '0;
                    bits_left_next = s_code_length;
                    if (lead_mark_reg != '0) begin
                        phase_next = PH_LEAD_MARK;
                    end else if (lead_space_reg != '0) begin
                        phase_next = PH_LEAD_SPACE;
                    end else begin
                        phase_next     = enter_phase;
                        bits_left_next = enter_bits;
                    end
                end
            end else if (phase_reg != PH_IDLE) begin
                if (phase_reg == PH_LEAD_SPACE || phase_reg == PH_BIT_SPACE) begin
                    us_cnt_next = us_inc;
                    phase_end   = (us_inc >= space_len);
                end else if (!half_reg) begin
                    if (us_inc >= {6'd0, high_len}) begin
                        half_next   = 1'b1;
                        us_cnt_next = '0;
                    end else begin
                        us_cnt_next = us_inc;
                    end
                end else begin
                    if (us_inc >= {6'd0, low_len}) begin
                        half_next    = 1'b0;
                        us_cnt_next  = '0;
                        cyc_cnt_next = cyc_inc;
                        phase_end    = (cyc_inc >= mark_len);
                    end else begin
                        us_cnt_next = us_inc;
                    end
                end
                // A mark whose length was written to zero while it runs ends on this tick.
                if (phase_reg != PH_LEAD_SPACE && phase_reg != PH_BIT_SPACE
                    && mark_len == '0) begin
                    phase_end = 1'b1;
                end
                // Move to the next phase, skipping any that take no time.
                if (phase_end) begin
                    half_next    = 1'b0;
                    us_cnt_next  = '0;
                    cyc_cnt_next = '0;
                    unique case (phase_reg)
                        PH_LEAD_MARK: begin
                            if (lead_space_reg != '0) begin
                                phase_next = PH_LEAD_SPACE;
                            end else begin
                                phase_next     = enter_phase;
                                bits_left_next = enter_bits;
                            end
                        end
                        PH_BIT_MARK: begin
                            if (space_len != '0) begin
                                phase_next = PH_BIT_SPACE;
                            end else begin
                                phase_next     = enter_phase;
                                bits_left_next = enter_bits;
                            end
                        end
                        PH_LEAD_SPACE, PH_BIT_SPACE: begin
                            phase_next     = enter_phase;
                            bits_left_next = enter_bits;
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end
        end
    end

    // Result word for the item being taken.
    always_comb begin
        res_level  = 1'b0;
        res_busy   = 1'b0;
        res_done   = 1'b0;
        res_status = STATUS_NONE;
        if (is_start) begin
            if (start_ok) begin
                res_status = STATUS_ACCEPT;
                res_busy   = (phase_next != PH_IDLE);
                res_done   = (phase_next == PH_IDLE);
            end else begin
                res_status = STATUS_REJECT;
                res_busy   = (phase_reg != PH_IDLE);
            end
        end else if (phase_reg != PH_IDLE) begin
            res_busy  = 1'b1;
            res_done  = (phase_next == PH_IDLE);
            res_level = (phase_reg == PH_LEAD_MARK || phase_reg == PH_BIT_MARK
                         || phase_reg == PH_TRAILER) && !half_reg;
        end
    end

    // Output register handshake.
    assign s_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            half_reg      <= 1'b0;
            us_cnt_reg    <= '0;
            cyc_cnt_reg   <= '0;
            shift_reg     <= '0;
            bits_left_reg <= '0;
            trailer_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            half_reg      <= half_next;
            us_cnt_reg    <= us_cnt_next;
            cyc_cnt_reg   <= cyc_cnt_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            trailer_reg   <= trailer_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (take) begin
            level_reg  <= res_level;
            busy_reg   <= res_busy;
            done_reg   <= res_done;
            status_reg <= res_status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_ir_level     = level_reg;
    assign m_busy_res     = busy_reg;
    assign m_done_res     = done_reg;
    assign m_start_status = status_reg;

endmodule
